>>> src/llc_pkg.sv
// shared types, constants and helpers for the card number luhn classifier
// used by llc_cell and card_number_luhn_classifier; no dependencies
`default_nettype none
package llc_pkg;

    localparam int CARD_W    = 63;
    localparam int NUM_DIGITS = 19;
    localparam int DIGIT_W   = 4;
    localparam int COUNT_W   = 5;
    localparam int BITCNT_W  = $clog2(CARD_W);

    localparam logic [1:0] VERDICT_INVALID = 2'd0;
    localparam logic [1:0] VERDICT_BRAND_A = 2'd1;
    localparam logic [1:0] VERDICT_BRAND_B = 2'd2;
    localparam logic [1:0] VERDICT_BRAND_C = 2'd3;

    typedef logic [DIGIT_W-1:0] digit_t;

    typedef struct packed {
        logic clear;
        logic shift;
        logic drain;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_DRAIN,
        ST_FIN
    } state_t;

    // digit sum of twice a decimal digit
    function automatic digit_t luhn_double(input digit_t d);
        digit_t r;
        unique case (d)
            4'd0: r = 4'd0;
            4'd1: r = 4'd2;
            4'd2: r = 4'd4;
            4'd3: r = 4'd6;
            4'd4: r = 4'd8;
            4'd5: r = 4'd1;
            4'd6: r = 4'd3;
            4'd7: r = 4'd5;
            4'd8: r = 4'd7;
            4'd9: r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> src/llc_cell.sv
// one bcd digit cell: shift-add-3 step during conversion, shift down during drain
// depends on llc_pkg
`default_nettype none
module llc_cell
    import llc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       bit_in,
    input  wire digit_t     digit_in,
    output logic            bit_out,
    output digit_t          digit_out
);

    digit_t digit_reg;
    digit_t digit_next;
    digit_t adj;

    // add 3 before shifting when the digit would overflow past nine
    always_comb
    begin
        adj = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    end

    always_comb
    begin
        priority if (ctrl.clear)
            digit_next = '0;
        else if (ctrl.shift)
            digit_next = {adj[DIGIT_W-2:0], bit_in};
        else if (ctrl.drain)
            digit_next = digit_in;
        else
            digit_next = digit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            digit_reg <= '0;
        else
            digit_reg <= digit_next;
    end

    assign bit_out   = adj[DIGIT_W-1];
    assign digit_out = digit_reg;

endmodule
`default_nettype wire

>>> src/card_number_luhn_classifier.sv
// top level: bcd cell chain, drain accumulator and classification
// depends on llc_pkg and llc_cell
// each word runs through bit-serial conversion, a drain of the digit row and a result load
// out_valid rises when the result is loaded, which waits until the output register is free
// a new word is held back until the previous one has gone through the bit-serial
// conversion in the cell row and the drain; a waiting result holds the next word back
// a new word is taken once the previous result has been loaded into the output register
// rst_n asynchronous active low clears the controller, the cells and the output valid
`default_nettype none
module card_number_luhn_classifier
    import llc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [CARD_W-1:0]   card_number,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [1:0]               verdict,
    output logic                     luhn_ok,
    output logic [COUNT_W-1:0]       digit_count
);

    state_t state_reg, state_next;

    // binary word shifted out msb first into cell 0
    logic [CARD_W-1:0]   bits_reg, bits_next;
    logic [BITCNT_W-1:0] cnt_reg, cnt_next;
    logic [COUNT_W-1:0]  pos_reg, pos_next;

    // drain side accumulators
    digit_t              sum_reg, sum_next;
    digit_t              prev_reg, prev_next;
    digit_t              hi_reg, hi_next;
    digit_t              lo_reg, lo_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          verdict_reg, verdict_next;
    logic                luhn_reg, luhn_next;
    logic [COUNT_W-1:0]  dcount_reg, dcount_next;

    cell_ctrl_t          ctrl;
    logic                accept;
    logic                load_out;
    logic                conv_last;
    logic                drain_last;

    logic   [NUM_DIGITS:0] carry;
    digit_t                dig [NUM_DIGITS+1];

    // cell row: cell 0 holds the least significant digit
    assign carry[0] = bits_reg[CARD_W-1];
    assign dig[NUM_DIGITS] = '0;

    for (genvar k = 0; k < NUM_DIGITS; k++)
    begin : g_cell
        llc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .bit_in    (carry[k]),
            .digit_in  (dig[k+1]),
            .bit_out   (carry[k+1]),
            .digit_out (dig[k])
        );
    end

    assign accept     = in_valid && in_ready;
    assign conv_last  = (cnt_reg == BITCNT_W'(CARD_W - 1));
    assign drain_last = (pos_reg == COUNT_W'(NUM_DIGITS - 1));
    assign load_out   = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_CONV;
            ST_CONV:  if (conv_last) state_next = ST_DRAIN;
            ST_DRAIN: if (drain_last) state_next = ST_FIN;
            ST_FIN:   if (load_out) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // controller outputs
    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE);
        ctrl.clear = accept;
        ctrl.shift = (state_reg == ST_CONV);
        ctrl.drain = (state_reg == ST_DRAIN);
    end

    // datapath
    always_comb
    begin
        digit_t       add;
        logic [4:0]   s;
        bits_next  = bits_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        prev_next  = prev_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        count_next = count_reg;
        add        = pos_reg[0] ? luhn_double(dig[0]) : dig[0];
        s          = {1'b0, sum_reg} + {1'b0, add};
        if (accept)
        begin
            bits_next  = card_number;
            cnt_next   = '0;
            pos_next   = '0;
            sum_next   = '0;
            prev_next  = '0;
            hi_next    = '0;
            lo_next    = '0;
            count_next = '0;
        end
        else if (state_reg == ST_CONV)
        begin
            bits_next = {bits_reg[CARD_W-2:0], 1'b0};
            cnt_next  = cnt_reg + 1'b1;
        end
        else if (state_reg == ST_DRAIN)
        begin
            // running sum kept modulo ten
            sum_next  = (s >= 5'd10) ? DIGIT_W'(s - 5'd10) : s[DIGIT_W-1:0];
            prev_next = dig[0];
            pos_next  = pos_reg + 1'b1;
            if (dig[0] != '0)
            begin
                count_next = pos_reg + 1'b1;
                hi_next    = dig[0];
                lo_next    = prev_reg;
            end
        end
    end

    // classification, first match wins
    always_comb
    begin
        logic ok;
        ok = (sum_reg == '0);
        luhn_next = ok;
        dcount_next = count_reg;
        verdict_next = VERDICT_INVALID;
        if (ok)
        begin
            priority if (count_reg == COUNT_W'(15) && hi_reg == 4'd3 &&
                         (lo_reg == 4'd4 || lo_reg == 4'd7))
                verdict_next = VERDICT_BRAND_A;
            else if (count_reg == COUNT_W'(16) && hi_reg == 4'd5 &&
                     lo_reg >= 4'd1 && lo_reg <= 4'd5)
                verdict_next = VERDICT_BRAND_B;
            else if ((count_reg == COUNT_W'(13) || count_reg == COUNT_W'(16)) &&
                     hi_reg == 4'd4)
                verdict_next = VERDICT_BRAND_C;
            else
                verdict_next = VERDICT_INVALID;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bits_reg  <= bits_next;
        sum_reg   <= sum_next;
        prev_reg  <= prev_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        count_reg <= count_next;
        if (load_out)
        begin
            verdict_reg <= verdict_next;
            luhn_reg    <= luhn_next;
            dcount_reg  <= dcount_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign verdict     = verdict_reg;
    assign luhn_ok     = luhn_reg;
    assign digit_count = dcount_reg;

endmodule
`default_nettype wire
